### rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the C token splitter: lexer modes, the
// burst of result bytes that one input word causes, and the queue depth.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Depth of the burst queue between the lexer and the output serializer.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NL = 8'h0A;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_OP     = 4'd1,
    M_SLASH  = 4'd2,
    M_WORD   = 4'd3,
    M_NUM    = 4'd4,
    M_DQ     = 4'd5,
    M_DQESC  = 4'd6,
    M_SQ     = 4'd7,
    M_LINE   = 4'd8,
    M_BLOCK  = 4'd9,
    M_BSTAR  = 4'd10,
    M_PENDNL = 4'd11
  } mode_t;

  // Up to three result bytes, oldest in data[0].
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
  } burst_t;

  // Lexer state together with the bytes produced on the way to it.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] pend;
    burst_t     burst;
  } step_t;

  // Write side of the burst queue.
  typedef struct packed {
    logic   push;
    burst_t burst;
  } q_wr_t;

endpackage

### rtl/c_token_splitter_top.sv
// ----------------------------------------------------------------------------
// c_token_splitter_top
// Splits a stream of C source bytes into tokens, one newline after each.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while in_full is low. The lexer
// resolves each byte in the cycle it is accepted and writes the zero to three
// token bytes it causes, as one burst, into a queue of QUEUE_DEPTH bursts;
// the output side hands out one byte per cycle while out_pop is high, with
// out_last set on the final byte of each burst. The output port's one byte
// per cycle sets the sustained rate: words, numbers and literals keep pace
// with the input, while separators and operator pairs add a byte or two that
// the queue absorbs. in_full rises only when the queue holds QUEUE_DEPTH
// bursts. A word with in_end_of_text set closes the open token and always
// yields at least one newline.
module c_token_splitter_top #(
  parameter int unsigned QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import cts_pkg::*;

  q_wr_t  q_wr;
  burst_t q_head;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  cts_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .in_full        (in_full),
    .q_wr           (q_wr)
  );

  cts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  cts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

### rtl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front
// Lexer front end: takes one source byte per cycle while q_full is low,
// advances the lexer mode and writes the burst of token bytes into the queue.
// ----------------------------------------------------------------------------
module cts_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  logic [7:0]     in_byte,
  input  logic           in_end_of_text,
  input  logic           q_full,
  output logic           in_full,
  output cts_pkg::q_wr_t q_wr
);
  import cts_pkg::*;

  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_BAR    = "|";
  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_DOT    = ".";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_DQUOTE = "\"";
  localparam logic [7:0] CH_SQUOTE = "'";
  localparam logic [7:0] CH_BSLASH = "\\";
  localparam logic [7:0] CH_USCORE = "_";

  mode_t      mode_r, mode_nxt;
  logic [7:0] pend_r, pend_nxt;
  step_t      step;
  logic       accept;

  function automatic burst_t push_byte(burst_t b, logic [7:0] x);
    burst_t r;
    r = b;
    if (b.cnt != 2'd3) begin
      r.data[b.cnt] = x;
      r.cnt         = b.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic doubles(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_LT) || (c == CH_GT) ||
           (c == CH_BAR) || (c == CH_AMP);
  endfunction

  // Start a new token with character c.
  function automatic step_t lex_begin(step_t s, logic [7:0] c);
    step_t r;
    r      = s;
    r.mode = M_IDLE;
    unique case (c)
      CH_SPACE, CH_TAB, CH_NL: begin
      end
      CH_SLASH: begin
        r.mode = M_SLASH;
      end
      CH_STAR, CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_EQ, CH_BAR, CH_AMP: begin
        r.burst = push_byte(r.burst, c);
        r.pend  = c;
        r.mode  = M_OP;
      end
      CH_HASH, CH_SEMI, CH_COLON, CH_COMMA, CH_DOT,
      CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN: begin
        r.burst = push_byte(r.burst, c);
        // With the burst already full the separator's newline goes out with the next word.
        if (r.burst.cnt != 2'd3) begin
          r.burst = push_byte(r.burst, CH_NL);
        end else begin
          r.mode = M_PENDNL;
        end
      end
      CH_DQUOTE: begin
        r.burst = push_byte(r.burst, c);
        r.mode  = M_DQ;
      end
      CH_SQUOTE: begin
        r.burst = push_byte(r.burst, c);
        r.mode  = M_SQ;
      end
      default: begin
        if (is_digit(c)) begin
          r.burst = push_byte(r.burst, c);
          r.mode  = M_NUM;
        end else if (is_alpha(c)) begin
          r.burst = push_byte(r.burst, c);
          r.mode  = M_WORD;
        end
      end
    endcase
    return r;
  endfunction

  // An operator either pairs with c or is closed and c starts a new token.
  function automatic step_t lex_op_next(step_t s, logic [7:0] c);
    step_t r;
    r = s;
    if ((c == CH_EQ) || ((c == r.pend) && doubles(r.pend))) begin
      r.burst = push_byte(r.burst, c);
      r.burst = push_byte(r.burst, CH_NL);
      r.mode  = M_IDLE;
    end else begin
      r.burst = push_byte(r.burst, CH_NL);
      r       = lex_begin(r, c);
    end
    return r;
  endfunction

  always_comb begin
    step       = '0;
    step.mode  = mode_r;
    step.pend  = pend_r;
    if (in_end_of_text) begin
      unique case (mode_r)
        M_OP, M_WORD, M_NUM, M_PENDNL: begin
          step.burst = push_byte(step.burst, CH_NL);
        end
        M_SLASH: begin
          step.burst = push_byte(step.burst, CH_SLASH);
          step.burst = push_byte(step.burst, CH_NL);
        end
        M_DQ, M_DQESC: begin
          step.burst = push_byte(step.burst, CH_DQUOTE);
          step.burst = push_byte(step.burst, CH_NL);
        end
        M_SQ: begin
          step.burst = push_byte(step.burst, CH_SQUOTE);
          step.burst = push_byte(step.burst, CH_NL);
        end
        default: begin
        end
      endcase
      step.burst = push_byte(step.burst, CH_NL);
      step.mode  = M_IDLE;
      step.pend  = '0;
    end else begin
      unique case (mode_r)
        M_OP: begin
          step = lex_op_next(step, in_byte);
        end
        M_SLASH: begin
          if (in_byte == CH_SLASH) begin
            step.mode = M_LINE;
          end else if (in_byte == CH_STAR) begin
            step.mode = M_BLOCK;
          end else begin
            step.burst = push_byte(step.burst, CH_SLASH);
            step.pend  = CH_SLASH;
            step       = lex_op_next(step, in_byte);
          end
        end
        M_WORD: begin
          if (is_alpha(in_byte) || is_digit(in_byte) || (in_byte == CH_USCORE)) begin
            step.burst = push_byte(step.burst, in_byte);
          end else begin
            step.burst = push_byte(step.burst, CH_NL);
            step       = lex_begin(step, in_byte);
          end
        end
        M_NUM: begin
          if (is_digit(in_byte) || (in_byte == CH_DOT)) begin
            step.burst = push_byte(step.burst, in_byte);
          end else begin
            step.burst = push_byte(step.burst, CH_NL);
            step       = lex_begin(step, in_byte);
          end
        end
        M_DQ: begin
          step.burst = push_byte(step.burst, in_byte);
          if (in_byte == CH_DQUOTE) begin
            step.burst = push_byte(step.burst, CH_NL);
            step.mode  = M_IDLE;
          end else if (in_byte == CH_BSLASH) begin
            step.mode = M_DQESC;
          end
        end
        M_DQESC: begin
          step.burst = push_byte(step.burst, in_byte);
          step.mode  = M_DQ;
        end
        M_SQ: begin
          step.burst = push_byte(step.burst, in_byte);
          if (in_byte == CH_SQUOTE) begin
            step.burst = push_byte(step.burst, CH_NL);
            step.mode  = M_IDLE;
          end
        end
        M_LINE: begin
          if (in_byte == CH_NL) begin
            step.mode = M_IDLE;
          end
        end
        M_BLOCK: begin
          if (in_byte == CH_STAR) begin
            step.mode = M_BSTAR;
          end
        end
        M_BSTAR: begin
          if (in_byte == CH_SLASH) begin
            step.mode = M_IDLE;
          end else if (in_byte != CH_STAR) begin
            step.mode = M_BLOCK;
          end
        end
        M_PENDNL: begin
          step.burst = push_byte(step.burst, CH_NL);
          step       = lex_begin(step, in_byte);
        end
        default: begin
          step = lex_begin(step, in_byte);
        end
      endcase
    end
  end

  assign accept  = in_push && !q_full;
  assign in_full = q_full;

  // Next state.
  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    if (accept) begin
      mode_nxt = step.mode;
      pend_nxt = step.pend;
    end
  end

  // Outputs: a word that yields no byte leaves the queue alone.
  always_comb begin
    q_wr.push  = accept && (step.burst.cnt != 2'd0);
    q_wr.burst = step.burst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

### rtl/cts_queue.sv
// ----------------------------------------------------------------------------
// cts_queue
// Small register queue of result bursts between the lexer and the
// output serializer. Full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module cts_queue #(
  parameter int unsigned DEPTH = cts_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cts_pkg::q_wr_t  q_wr,
  input  logic            q_pop,
  output logic            q_full,
  output logic            q_empty,
  output cts_pkg::burst_t q_head
);
  import cts_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  burst_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.burst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back
// Output serializer: hands out the bytes of the burst at the queue head
// one per pop and flags the final byte of each burst.
// ----------------------------------------------------------------------------
module cts_back (
  input  logic            clk,
  input  logic            rst_n,
  input  cts_pkg::burst_t q_head,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import cts_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       take;

  assign out_empty = q_empty;
  assign out_byte  = q_head.data[idx_r];
  assign out_last  = (idx_r == (q_head.cnt - 2'd1));
  assign take      = out_pop && !q_empty;
  assign q_pop     = take && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = out_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

### rtl/cts_checker.sv
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks of the token splitter, bound to the top level.
// ----------------------------------------------------------------------------
module cts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic [7:0] in_byte,
  input logic       in_end_of_text,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // An end-of-text word always leaves at least a newline to read.
  a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_end_of_text |=> !out_empty)
    else $error("end of text left the output empty");

  // Nothing shows up on the output unless a word was taken in.
  a_no_invented_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty && !(in_push && !in_full) |=> out_empty)
    else $error("output word appeared without an accepted input word");

  // A waiting output word holds until it is taken.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_byte) && $stable(out_last))
    else $error("waiting output word changed");

endmodule

bind c_token_splitter_top cts_checker u_cts_checker (.*);

### bench/cts_token_checker.sv
// ----------------------------------------------------------------------------
// cts_token_checker
// Watches both channels of the C token splitter. It runs its own lexer on
// every accepted source word, queues the token words it predicts, and
// compares each popped word with the oldest prediction.
// ----------------------------------------------------------------------------
module cts_token_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         tokens_waiting,
  output int         mismatches,
  output int         tokens_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import cts_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } tok_word_t;

  tok_word_t  token_q[$];
  tok_word_t  want;
  mode_t      lex_mode = M_IDLE;
  logic [7:0] lex_pend = '0;
  logic [7:0] burst_b[3];
  int         burst_n;
  int         err_cnt = 0;
  int         seen_cnt = 0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit pairs_with_itself(input logic [7:0] c);
    return c == "+" || c == "-" || c == "<" || c == ">" || c == "|" || c == "&";
  endfunction

  // One input word never yields more than three token words.
  task automatic put_byte(input logic [7:0] b);
    if (burst_n < 3) begin
      burst_b[burst_n] = b;
      burst_n++;
    end
  endtask

  task automatic start_token(input logic [7:0] c);
    lex_mode = M_IDLE;
    case (c)
      " ", "\t", CH_NL: ;
      "/": lex_mode = M_SLASH;
      "*", "+", "-", "<", ">", "=", "|", "&": begin
        put_byte(c);
        lex_pend = c;
        lex_mode = M_OP;
      end
      "#", ";", ":", ",", ".", "{", "}", "(", ")": begin
        put_byte(c);
        // With the burst already full, the separator's newline moves to the next word.
        if (burst_n < 3) put_byte(CH_NL);
        else lex_mode = M_PENDNL;
      end
      "\"": begin
        put_byte(c);
        lex_mode = M_DQ;
      end
      "'": begin
        put_byte(c);
        lex_mode = M_SQ;
      end
      default: begin
        if (is_digit(c)) begin
          put_byte(c);
          lex_mode = M_NUM;
        end else if (is_alpha(c)) begin
          put_byte(c);
          lex_mode = M_WORD;
        end
      end
    endcase
  endtask

  task automatic op_follow(input logic [7:0] c);
    if (c == "=" || (c == lex_pend && pairs_with_itself(lex_pend))) begin
      put_byte(c);
      put_byte(CH_NL);
      lex_mode = M_IDLE;
    end else begin
      put_byte(CH_NL);
      start_token(c);
    end
  endtask

  task automatic lex_word(input logic [7:0] c, input logic eot);
    burst_n = 0;
    if (eot) begin
      case (lex_mode)
        M_OP, M_WORD, M_NUM, M_PENDNL: put_byte(CH_NL);
        M_SLASH: begin
          put_byte("/");
          put_byte(CH_NL);
        end
        M_DQ, M_DQESC: begin
          put_byte("\"");
          put_byte(CH_NL);
        end
        M_SQ: begin
          put_byte("'");
          put_byte(CH_NL);
        end
        default: ;
      endcase
      put_byte(CH_NL);
      lex_mode = M_IDLE;
      lex_pend = '0;
    end else begin
      case (lex_mode)
        M_OP: op_follow(c);
        M_SLASH: begin
          if (c == "/") lex_mode = M_LINE;
          else if (c == "*") lex_mode = M_BLOCK;
          else begin
            put_byte("/");
            lex_pend = "/";
            op_follow(c);
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_") put_byte(c);
          else begin
            put_byte(CH_NL);
            start_token(c);
          end
        end
        M_NUM: begin
          if (is_digit(c) || c == ".") put_byte(c);
          else begin
            put_byte(CH_NL);
            start_token(c);
          end
        end
        M_DQ: begin
          put_byte(c);
          if (c == "\"") begin
            put_byte(CH_NL);
            lex_mode = M_IDLE;
          end else if (c == "\\") begin
            lex_mode = M_DQESC;
          end
        end
        M_DQESC: begin
          put_byte(c);
          lex_mode = M_DQ;
        end
        M_SQ: begin
          put_byte(c);
          if (c == "'") begin
            put_byte(CH_NL);
            lex_mode = M_IDLE;
          end
        end
        M_LINE: if (c == CH_NL) lex_mode = M_IDLE;
        M_BLOCK: if (c == "*") lex_mode = M_BSTAR;
        M_BSTAR: begin
          if (c == "/") lex_mode = M_IDLE;
          else if (c != "*") lex_mode = M_BLOCK;
        end
        M_PENDNL: begin
          put_byte(CH_NL);
          start_token(c);
        end
        default: start_token(c);
      endcase
    end
    for (int i = 0; i < burst_n; i++) begin
      token_q.push_back('{ch: burst_b[i], is_last: (i == burst_n - 1)});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_mode = M_IDLE;
      lex_pend = '0;
      token_q.delete();
    end else begin
      if (in_push && !in_full) lex_word(in_byte, in_end_of_text);
      if (out_pop && !out_empty) begin
        seen_cnt++;
        if (token_q.size() == 0) begin
          $error("out_byte: expected nothing, actual %h", out_byte);
          err_cnt++;
        end else begin
          want = token_q.pop_front();
          if (out_byte !== want.ch) begin
            $error("out_byte: expected %h, actual %h", want.ch, out_byte);
            err_cnt++;
          end
          if (out_last !== want.is_last) begin
            $error("out_last: expected %b, actual %b", want.is_last, out_last);
            err_cnt++;
          end
        end
      end
    end
    tokens_waiting <= token_q.size();
    mismatches     <= err_cnt;
    tokens_checked <= seen_cnt;
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives C source text into the token splitter: a short directed stretch
// over each token kind and some corner cases, then random snippets of
// code-like text in three idling phases. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_byte = '0;
  logic       in_end_of_text = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int tokens_waiting;
  int mismatches;
  int tokens_checked;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int eot_sent = 0;

  logic [7:0] frag_q[$];

  c_token_splitter_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  cts_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .tokens_waiting (tokens_waiting),
    .mismatches     (mismatches),
    .tokens_checked (tokens_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_pop <= (rst_n && $urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_word(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push        <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_full);
    words_sent++;
    if (eot) eot_sent++;
  endtask

  // The waiting count is registered, so the task always waits on a clock edge first.
  task automatic drain_tokens();
    in_push <= 1'b0;
    do @(posedge clk); while (tokens_waiting != 0);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] text_char(input logic [7:0] avoid);
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == avoid || c == "\\") c = "q";
    return c;
  endfunction

  // Builds one snippet of C-like text; returns 0 for lone noise words.
  function automatic bit make_fragment();
    int kind;
    logic [7:0] op;
    kind = $urandom_range(0, 99);
    frag_q.delete();
    if (kind < 18) begin
      frag_q.push_back($urandom_range(0, 1) ? pick("abcdefghijklmnopqrstuvwxyz")
                                            : pick("ABCDEFGHIJKLMNOPQRSTUVWXYZ"));
      repeat ($urandom_range(0, 5)) frag_q.push_back(pick("abzAZ_09xQ7"));
    end else if (kind < 28) begin
      frag_q.push_back(pick("0123456789"));
      repeat ($urandom_range(0, 4)) frag_q.push_back(pick("0123456789."));
    end else if (kind < 43) begin
      op = pick("*+-<>=|&/");
      frag_q.push_back(op);
      case ($urandom_range(0, 2))
        1: frag_q.push_back(op);
        2: frag_q.push_back("=");
        default: ;
      endcase
    end else if (kind < 53) begin
      frag_q.push_back(pick("#;:,.{}()"));
    end else if (kind < 60) begin
      repeat ($urandom_range(1, 2)) frag_q.push_back(pick(" \t\n"));
    end else if (kind < 66) begin
      frag_q.push_back("/");
      frag_q.push_back("/");
      repeat ($urandom_range(0, 4)) frag_q.push_back(8'($urandom_range(0, 255)));
      frag_q.push_back("\n");
    end else if (kind < 73) begin
      frag_q.push_back("/");
      frag_q.push_back("*");
      repeat ($urandom_range(0, 5)) frag_q.push_back(pick("*/a *"));
      frag_q.push_back("*");
      frag_q.push_back("/");
    end else if (kind < 81) begin
      frag_q.push_back("\"");
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 3) == 0) begin
          frag_q.push_back("\\");
          frag_q.push_back(pick("\"\\na"));
        end else begin
          frag_q.push_back(text_char("\""));
        end
      end
      if ($urandom_range(0, 99) < 85) frag_q.push_back("\"");
    end else if (kind < 87) begin
      frag_q.push_back("'");
      repeat ($urandom_range(0, 3)) frag_q.push_back(text_char("'"));
      if ($urandom_range(0, 99) < 85) frag_q.push_back("'");
    end else begin
      frag_q.push_back(8'($urandom_range(0, 255)));
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic random_phase(input int n_words);
    int count;
    bit counts;
    count = 0;
    while (count < n_words) begin
      if ($urandom_range(0, 99) < 3) begin
        send_word(8'($urandom_range(0, 255)), 1'b1);
        count++;
      end else begin
        counts = make_fragment();
        foreach (frag_q[i]) send_word(frag_q[i], 1'b0);
        if (counts) count += frag_q.size();
      end
    end
  endtask

  initial begin
    string demo;
    demo = "x_9++/;(/*/*/\"\\\"\"'\\'//\n1.5";
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Words, doubled operators, a lone slash closed by a mark, both comment forms,
    // a string escape, a backslash char literal, dropped bytes and the end mark.
    foreach (demo[i]) send_word(demo[i], 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b1);
    drain_tokens();

    send_idle_pct = 8;
    recv_idle_pct <= 53;
    random_phase(137);
    drain_tokens();

    send_idle_pct = 53;
    recv_idle_pct <= 8;
    random_phase(137);
    drain_tokens();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    random_phase(137);
    send_word(8'h00, 1'b1);

    drain_tokens();
    repeat (16) @(posedge clk);

    $display("Fed %0d source words (%0d end-of-text marks) through three idling phases,",
             words_sent, eot_sent);
    $display("and compared %0d token words with the predicted stream.", tokens_checked);
    if (mismatches == 0 && tokens_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cts_pkg.sv
rtl/cts_front.sv
rtl/cts_queue.sv
rtl/cts_back.sv
rtl/c_token_splitter_top.sv
rtl/cts_checker.sv
bench/cts_token_checker.sv
bench/tb_top.sv
